/* rtl/dbe_pkg.sv */
// Shared constants, types and register codes of the debounce event block.
`default_nettype none
package dbe_pkg;

  localparam int CHANNELS       = 8;
  localparam int TIME_BITS      = 48;
  localparam int COUNT_BITS     = 4;
  localparam int IDX_BITS       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SAMPLE_BITS    = 8;
  localparam int PN_BITS        = 16;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int IN_TDATA_BITS  = 72;
  localparam int OUT_TDATA_BITS = 80;
  localparam int OUT_USED_BITS  = PN_BITS + 1 + TIME_BITS + SAMPLE_BITS;

  localparam logic [COUNT_BITS-1:0] SETTLE_RESET = COUNT_BITS'(3);
  localparam logic                  ACT_INIT     = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_INVERT_MASK  = 2'd0,
    REG_SETTLE_TICKS = 2'd1,
    REG_FIRST_POINT  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CHANNELS-1:0]   invert_mask;
    logic [COUNT_BITS-1:0] settle_ticks;
    logic [PN_BITS-1:0]    first_point;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] cnt;
    logic [TIME_BITS-1:0]  tm;
  } chan_ent_t;

endpackage
`default_nettype wire

/* rtl/dbe_cfg_regs.sv */
// Configuration register file of the debounce event block.
`default_nettype none
module dbe_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dbe_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [dbe_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output dbe_pkg::cfg_t                          cfg
);
  import dbe_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert_mask  <= '0;
      cfg_r.settle_ticks <= SETTLE_RESET;
      cfg_r.first_point  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INVERT_MASK:  cfg_r.invert_mask  <= cfg_data[CHANNELS-1:0];
        REG_SETTLE_TICKS: cfg_r.settle_ticks <= cfg_data[COUNT_BITS-1:0];
        REG_FIRST_POINT:  cfg_r.first_point  <= cfg_data[PN_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/multi_channel_input_debounce_events_top.sv */
// Top level of the eight-channel input debounce with change events.
// A sample tick after initialise takes the item from the input register and arms changed
// channels, then scans the eight channel slots with one read per cycle of the per-channel
// counter/time memory while not stalled (read, update, write back, pipelined one deep),
// and then gives the status result. An initialise or a tick before initialise goes
// straight to the status result. Output back-pressure stalls the engine; one further
// input item is held while the current one is in work.
`default_nettype none
module multi_channel_input_debounce_events_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // sample_a, sample_b, sample_c, timestamp
  input  wire logic [dbe_pkg::IN_TDATA_BITS-1:0]  in_tdata,
  // action
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // point_number, new_value, event_time, stable_state, zero fill
  output logic [dbe_pkg::OUT_TDATA_BITS-1:0]      out_tdata,
  // is_event
  output logic                                    out_tuser,
  output logic                                    out_tlast,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [dbe_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [dbe_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import dbe_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_STATUS} state_t;

  cfg_t cfg;

  dbe_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  state_t                 state_r;
  logic                   hold_valid_r;
  logic                   hold_act_r;
  logic [SAMPLE_BITS-1:0] hold_a_r, hold_b_r, hold_c_r;
  logic [TIME_BITS-1:0]   hold_now_r;

  logic [CHANNELS-1:0]    prev_r, stable_r, armed_r, chg_r, cur_a_r;
  logic                   init_r;
  logic [TIME_BITS-1:0]   now_r;

  logic                   iss_r;
  logic [IDX_BITS-1:0]    ra_r;
  logic                   b_valid_r;
  logic [IDX_BITS-1:0]    b_idx_r;

  chan_ent_t              mem [CHANNELS];
  chan_ent_t              rdata_r;

  logic                   out_valid_r;
  logic                   out_event_r;
  logic [PN_BITS-1:0]     out_pn_r;
  logic                   out_nv_r;
  logic [TIME_BITS-1:0]   out_time_r;
  logic [SAMPLE_BITS-1:0] out_stable_r;
  logic                   out_last_r;

  logic                   adv;
  logic [CHANNELS-1:0]    a_x, b_x, c_x, maj, chg;
  logic                   b_todo, b_chg, b_zero, b_emit;
  logic [COUNT_BITS-1:0]  cnt_cur;
  logic [TIME_BITS-1:0]   tm_cur;
  chan_ent_t              wdata;
  logic                   mem_we, mem_re;
  logic [CHANNELS-1:0]    stable_upd;
  logic                   start;
  logic                   out_load;

  assign in_tready  = !hold_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_event_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_TDATA_BITS - OUT_USED_BITS)'(0),
                       SAMPLE_BITS'(out_stable_r), out_time_r, out_nv_r, out_pn_r};

  assign adv   = !out_valid_r || out_tready;
  assign start = (state_r == ST_IDLE) && hold_valid_r;

  always_comb begin
    a_x     = hold_a_r[CHANNELS-1:0] ^ cfg.invert_mask;
    b_x     = hold_b_r[CHANNELS-1:0] ^ cfg.invert_mask;
    c_x     = hold_c_r[CHANNELS-1:0] ^ cfg.invert_mask;
    maj     = (a_x & b_x) | (a_x & c_x) | (b_x & c_x);
    chg     = a_x ^ prev_r;

    b_todo  = armed_r[b_idx_r];
    b_chg   = chg_r[b_idx_r];
    cnt_cur = b_chg ? cfg.settle_ticks : rdata_r.cnt;
    tm_cur  = b_chg ? now_r : rdata_r.tm;
    b_zero  = (cnt_cur == '0);
    b_emit  = b_todo && b_zero && (cur_a_r[b_idx_r] != stable_r[b_idx_r]);

    wdata.cnt = b_zero ? cnt_cur : cnt_cur - COUNT_BITS'(1);
    wdata.tm  = tm_cur;

    stable_upd          = stable_r;
    stable_upd[b_idx_r] = cur_a_r[b_idx_r];

    mem_we = (state_r == ST_SCAN) && adv && b_valid_r && b_todo;
    mem_re = (state_r == ST_SCAN) && adv && iss_r;

    out_load = adv && (((state_r == ST_SCAN) && b_valid_r && b_emit) ||
                       (state_r == ST_STATUS));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[b_idx_r] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[ra_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hold_valid_r <= 1'b0;
      prev_r       <= '0;
      stable_r     <= '0;
      armed_r      <= '0;
      init_r       <= 1'b0;
      iss_r        <= 1'b0;
      ra_r         <= '0;
      b_valid_r    <= 1'b0;
      b_idx_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        hold_valid_r <= 1'b1;
        hold_a_r     <= in_tdata[7:0];
        hold_b_r     <= in_tdata[15:8];
        hold_c_r     <= in_tdata[23:16];
        hold_now_r   <= in_tdata[71:24];
        hold_act_r   <= in_tuser;
      end

      if (out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (start) begin
            hold_valid_r <= 1'b0;
            if (hold_act_r == ACT_INIT) begin
              prev_r   <= maj;
              stable_r <= maj;
              init_r   <= 1'b1;
              state_r  <= ST_STATUS;
            end else if (!init_r) begin
              state_r <= ST_STATUS;
            end else begin
              prev_r    <= a_x;
              armed_r   <= armed_r | chg;
              chg_r     <= chg;
              cur_a_r   <= a_x;
              now_r     <= hold_now_r;
              iss_r     <= 1'b1;
              ra_r      <= '0;
              b_valid_r <= 1'b0;
              state_r   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (adv) begin
            if (iss_r) begin
              b_valid_r <= 1'b1;
              b_idx_r   <= ra_r;
              if (ra_r == IDX_BITS'(CHANNELS - 1)) begin
                iss_r <= 1'b0;
              end else begin
                ra_r <= ra_r + IDX_BITS'(1);
              end
            end else begin
              b_valid_r <= 1'b0;
            end
            if (b_valid_r) begin
              if (b_todo && b_zero) begin
                armed_r[b_idx_r] <= 1'b0;
              end
              if (b_emit) begin
                stable_r     <= stable_upd;
                out_valid_r  <= 1'b1;
                out_event_r  <= 1'b1;
                out_pn_r     <= PN_BITS'(cfg.first_point + PN_BITS'(b_idx_r));
                out_nv_r     <= cur_a_r[b_idx_r];
                out_time_r   <= tm_cur;
                out_stable_r <= SAMPLE_BITS'(stable_upd);
                out_last_r   <= 1'b0;
              end
              if (b_idx_r == IDX_BITS'(CHANNELS - 1)) begin
                state_r <= ST_STATUS;
              end
            end
          end
        end
        ST_STATUS: begin
          if (adv) begin
            out_valid_r  <= 1'b1;
            out_event_r  <= 1'b0;
            out_pn_r     <= '0;
            out_nv_r     <= 1'b0;
            out_time_r   <= '0;
            out_stable_r <= SAMPLE_BITS'(stable_r);
            out_last_r   <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
